/* src/ptd_pkg.sv */
// Shared types, register codes and palette expansion helpers for the paletted
// texture decoder. No dependencies.
`default_nettype none

package ptd_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int FMT_W      = 4;
   localparam int DIM_REG_W  = 13;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 2'd2;

   // format codes
   localparam logic [FMT_W-1:0] FMT_P4_RGB8   = 4'd0;
   localparam logic [FMT_W-1:0] FMT_P4_RGBA8  = 4'd1;
   localparam logic [FMT_W-1:0] FMT_P4_RGB565 = 4'd2;
   localparam logic [FMT_W-1:0] FMT_P4_RGBA4  = 4'd3;
   localparam logic [FMT_W-1:0] FMT_P4_RGB5A1 = 4'd4;
   localparam logic [FMT_W-1:0] FMT_P8_RGB8   = 4'd5;
   localparam logic [FMT_W-1:0] FMT_P8_RGBA8  = 4'd6;
   localparam logic [FMT_W-1:0] FMT_P8_RGB565 = 4'd7;
   localparam logic [FMT_W-1:0] FMT_P8_RGBA4  = 4'd8;
   localparam logic [FMT_W-1:0] FMT_P8_RGB5A1 = 4'd9;

   typedef enum logic [2:0] {
      ENC_RGB8,
      ENC_RGBA8,
      ENC_RGB565,
      ENC_RGBA4,
      ENC_RGB5A1
   } enc_type;

   typedef enum logic {
      PH_PALETTE,
      PH_INDEX
   } phase_type;

   typedef struct packed {
      logic    known;
      logic    wide;
      enc_type enc;
   } fmt_type;

   // tag that travels with a palette read
   typedef struct packed {
      logic valid;
      logic last;
      logic zero;
   } rd_tag_type;

   typedef struct packed {
      logic       last_pixel;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   function automatic fmt_type decode_format(logic [FMT_W-1:0] code);
      fmt_type f;
      f = '{known: 1'b1, wide: 1'b0, enc: ENC_RGB8};
      case (code)
         FMT_P4_RGB8:   f.enc = ENC_RGB8;
         FMT_P4_RGBA8:  f.enc = ENC_RGBA8;
         FMT_P4_RGB565: f.enc = ENC_RGB565;
         FMT_P4_RGBA4:  f.enc = ENC_RGBA4;
         FMT_P4_RGB5A1: f.enc = ENC_RGB5A1;
         FMT_P8_RGB8:   begin f.wide = 1'b1; f.enc = ENC_RGB8;   end
         FMT_P8_RGBA8:  begin f.wide = 1'b1; f.enc = ENC_RGBA8;  end
         FMT_P8_RGB565: begin f.wide = 1'b1; f.enc = ENC_RGB565; end
         FMT_P8_RGBA4:  begin f.wide = 1'b1; f.enc = ENC_RGBA4;  end
         FMT_P8_RGB5A1: begin f.wide = 1'b1; f.enc = ENC_RGB5A1; end
         default:       f.known = 1'b0;
      endcase
      return f;
   endfunction

   // byte position of the final byte of one palette entry
   function automatic logic [1:0] entry_last_pos(enc_type enc);
      logic [1:0] p;
      case (enc)
         ENC_RGB8:  p = 2'd2;
         ENC_RGBA8: p = 2'd3;
         default:   p = 2'd1;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] rep4(logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] rep5(logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] rep6(logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // raw little-endian entry to {a, b, g, r}
   function automatic logic [31:0] expand_entry(enc_type enc, logic [31:0] raw);
      logic [15:0] v;
      logic [31:0] res;
      v = raw[15:0];
      case (enc)
         ENC_RGB8:   res = {8'hFF, raw[23:0]};
         ENC_RGBA8:  res = raw;
         ENC_RGB565: res = {8'hFF, rep5(v[4:0]), rep6(v[10:5]), rep5(v[15:11])};
         ENC_RGBA4:  res = {rep4(v[3:0]), rep4(v[7:4]), rep4(v[11:8]), rep4(v[15:12])};
         default:    res = {(v[0] ? 8'hFF : 8'h00), rep5(v[5:1]), rep5(v[10:6]),
                            rep5(v[15:11])};
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* src/ptd_req_if.sv */
// Input byte channel of the paletted texture decoder.
// Standalone, no package use.
`default_nettype none

interface ptd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* src/ptd_rsp_if.sv */
// Pixel result channel of the paletted texture decoder.
// Standalone, no package use.
`default_nettype none

interface ptd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output last_pixel, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

/* src/ptd_csr_if.sv */
// Register write channel of the paletted texture decoder.
// Standalone; widths match the register list of ptd_pkg.
`default_nettype none

interface ptd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [12:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* src/ptd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ptd_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/ptd_palette_fill.sv */
// Palette phase: assembles entry bytes, expands them and writes the palette RAM.
// Uses ptd_pkg.
`default_nettype none

module ptd_palette_fill #(
   parameter int  PALETTE_DEPTH = 256,
   localparam int AW            = $clog2(PALETTE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             restart,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire ptd_pkg::fmt_type fmt,
   output logic                  index_phase,
   output logic                  wr_en,
   output logic      [AW-1:0]    wr_addr,
   output logic      [31:0]      wr_data
);
   import ptd_pkg::*;

   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  slot_ff, slot_in;
   logic [23:0] asm_ff, asm_in;
   logic [23:0] asm_next;
   logic        pos_last, slot_last;
   logic [31:0] raw;

   assign pos_last  = (pos_ff == entry_last_pos(fmt.enc));
   assign slot_last = (slot_ff == (fmt.wide ? 8'hFF : 8'h0F));

   always_comb begin
      asm_next = asm_ff;
      case (pos_ff)
         2'd0:    asm_next[7:0]   = data_byte;
         2'd1:    asm_next[15:8]  = data_byte;
         2'd2:    asm_next[23:16] = data_byte;
         default: asm_next        = asm_ff;
      endcase
   end

   assign raw     = {((pos_ff == 2'd3) ? data_byte : 8'h00), asm_next};
   assign wr_en   = accept && pos_last && ({1'b0, slot_ff} < DEPTH9);
   assign wr_addr = slot_ff[AW-1:0];
   assign wr_data = expand_entry(fmt.enc, raw);

   // next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_PALETTE: if (accept && pos_last && slot_last) begin
            phase_in = PH_INDEX;
         end
         PH_INDEX:   phase_in = PH_INDEX;
         default:    phase_in = PH_PALETTE;
      endcase
      if (restart) begin
         phase_in = PH_PALETTE;
      end
   end

   // outputs
   always_comb begin
      case (phase_ff)
         PH_INDEX: index_phase = 1'b1;
         default:  index_phase = 1'b0;
      endcase
   end

   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      asm_in  = asm_ff;
      if (restart) begin
         pos_in  = 2'd0;
         slot_in = 8'd0;
         asm_in  = 24'd0;
      end else if (accept) begin
         if (pos_last) begin
            pos_in  = 2'd0;
            asm_in  = 24'd0;
            slot_in = slot_last ? 8'd0 : slot_ff + 8'd1;
         end else begin
            pos_in = pos_ff + 2'd1;
            asm_in = asm_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PALETTE;
         pos_ff   <= 2'd0;
         slot_ff  <= 8'd0;
         asm_ff   <= 24'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         asm_ff   <= asm_in;
      end
   end

endmodule

`default_nettype wire

/* src/ptd_index_issue.sv */
// Index phase: holds one index byte, counts pixels and issues palette reads.
// Uses ptd_pkg.
`default_nettype none

module ptd_index_issue #(
   parameter int  PALETTE_DEPTH = 256,
   parameter int  MAX_DIMENSION = 4096,
   localparam int AW            = $clog2(PALETTE_DEPTH)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              restart,
   input  wire logic                              accept,
   input  wire logic [7:0]                        data_byte,
   input  wire logic                              wide,
   input  wire logic [ptd_pkg::DIM_REG_W-1:0]     image_width,
   input  wire logic [ptd_pkg::DIM_REG_W-1:0]     image_height,
   input  wire logic                              room,
   output logic                                   take_ok,
   output ptd_pkg::rd_tag_type                    rd_tag,
   output logic      [AW-1:0]                     rd_addr
);
   import ptd_pkg::*;

   localparam int         DIM_W  = $clog2(MAX_DIMENSION + 1);
   localparam int         CNT_W  = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);
   localparam logic [DIM_REG_W:0] MAXD = (DIM_REG_W + 1)'(MAX_DIMENSION);

   logic [DIM_REG_W:0]   w_ext, h_ext, w_clamp, h_clamp;
   logic [2*DIM_W-1:0]   product;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     done_ff, done_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_hi_ff, pend_hi_in;
   logic [7:0]           pend_byte_ff, pend_byte_in;
   logic [7:0]           idx;
   logic                 exhausted, can_issue, finish;

   // pixel total, settled long before the first index byte arrives
   assign w_ext    = {1'b0, image_width};
   assign h_ext    = {1'b0, image_height};
   assign w_clamp  = (w_ext > MAXD) ? MAXD : w_ext;
   assign h_clamp  = (h_ext > MAXD) ? MAXD : h_ext;
   assign product  = w_clamp[DIM_W-1:0] * h_clamp[DIM_W-1:0];
   assign total_in = product[CNT_W-1:0];

   assign idx = wide       ? pend_byte_ff :
                pend_hi_ff ? {4'h0, pend_byte_ff[7:4]} : {4'h0, pend_byte_ff[3:0]};

   assign exhausted = (done_ff >= total_ff);
   assign can_issue = pend_valid_ff && !exhausted && room;
   assign finish    = pend_valid_ff && (exhausted || (can_issue && (wide || pend_hi_ff)));
   assign take_ok   = !pend_valid_ff || finish;

   assign rd_tag.valid = can_issue;
   assign rd_tag.last  = ((done_ff + CNT_W'(1)) == total_ff);
   assign rd_tag.zero  = ({1'b0, idx} >= DEPTH9);
   assign rd_addr      = idx[AW-1:0];

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_hi_in    = pend_hi_ff;
      pend_byte_in  = pend_byte_ff;
      done_in       = done_ff;
      if (restart) begin
         pend_valid_in = 1'b0;
         pend_hi_in    = 1'b0;
         done_in       = '0;
      end else begin
         if (can_issue) begin
            done_in    = done_ff + CNT_W'(1);
            pend_hi_in = 1'b1;
         end
         if (accept) begin
            pend_valid_in = 1'b1;
            pend_hi_in    = 1'b0;
            pend_byte_in  = data_byte;
         end else if (finish) begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_hi_ff    <= 1'b0;
         done_ff       <= '0;
         total_ff      <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_hi_ff    <= pend_hi_in;
         done_ff       <= done_in;
         total_ff      <= total_in;
      end
      pend_byte_ff <= pend_byte_in;
   end

endmodule

`default_nettype wire

/* src/ptd_out_queue.sv */
// Two-beat result queue behind the palette RAM read, with credit for reads in flight.
// Uses ptd_pkg.
`default_nettype none

module ptd_out_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ptd_pkg::rd_tag_type rd_tag,
   input  wire logic [31:0]         rd_data,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output ptd_pkg::pix_type         rsp_pix,
   output logic                     room
);
   import ptd_pkg::*;

   localparam logic [2:0] QDEPTH = 3'd2;

   rd_tag_type tag_ff;
   pix_type    slot_ff [2];
   pix_type    entry;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] occ_ff, occ_in;
   logic       push, pop;
   logic [2:0] committed;

   assign entry = tag_ff.zero ? pix_type'({tag_ff.last, 32'h0}) :
                                pix_type'({tag_ff.last, rd_data});

   assign push      = tag_ff.valid;
   assign pop       = (occ_ff != 2'd0) && rsp_ready;
   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_pix   = slot_ff[rd_ptr_ff];

   // beats held after this edge, counting the read in flight
   assign committed = {1'b0, occ_ff} + {2'b00, tag_ff.valid} - {2'b00, pop};
   assign room      = (committed < QDEPTH);

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
   assign occ_in    = occ_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= 2'd0;
      end else begin
         tag_ff    <= rd_tag;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

/* src/paletted_texture_decoder.sv */
// Top level of the paletted texture decoder: register block, palette RAM and datapath.
// Uses ptd_pkg, the three channel interfaces, ptd_ram, ptd_palette_fill,
// ptd_index_issue and ptd_out_queue.
//
// The decoder takes a compressed paletted texture one byte per beat. It first
// collects the palette (16 entries for 4-bit index formats, 256 for 8-bit ones),
// expands each entry to RGBA8 and writes it into a single-port-write palette RAM.
// Then every index byte turns into one pixel (8-bit indices) or two pixels
// (4-bit indices, low nibble first), each a RAM lookup, delivered as one RGBA8
// beat with last_pixel set on the final pixel of the image. Palette bytes are
// taken at one per cycle, and 8-bit index bytes too while the result queue has
// room; a 4-bit index byte is held until both its pixels are issued, since the
// RAM has one read port and the result channel moves one pixel per beat. A pixel
// passes the held index byte, the RAM read register and the result queue; the
// high-nibble pixel of a 4-bit byte follows the low-nibble one. A two-beat queue
// behind the RAM keeps input flowing while a result waits. A mapped register write
// restarts the palette/pixel counters (palette contents are kept); write only
// while the block is idle. Unknown format codes drop all bytes; bytes after the
// last pixel are dropped. Indices at or above PALETTE_DEPTH read as zero color.
`default_nettype none

module paletted_texture_decoder #(
   parameter int PALETTE_DEPTH = 256,
   parameter int MAX_DIMENSION = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ptd_req_if.sink     req_bus,
   ptd_rsp_if.source   rsp_bus,
   ptd_csr_if.sink     csr_bus
);
   import ptd_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   // ---- register block ----
   logic [FMT_W-1:0]     format_code_ff, format_code_in;
   logic [DIM_REG_W-1:0] image_width_ff, image_width_in;
   logic [DIM_REG_W-1:0] image_height_ff, image_height_in;
   logic                 csr_write;
   logic                 restart;
   fmt_type              fmt;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      format_code_in  = format_code_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      restart         = 1'b0;
      if (csr_write) begin
         case (csr_bus.addr)
            CSR_FORMAT: begin
               format_code_in = csr_bus.wdata[FMT_W-1:0];
               restart        = 1'b1;
            end
            CSR_WIDTH: begin
               image_width_in = csr_bus.wdata;
               restart        = 1'b1;
            end
            CSR_HEIGHT: begin
               image_height_in = csr_bus.wdata;
               restart         = 1'b1;
            end
            default: restart = 1'b0;   // unmapped index: no effect
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_code_ff  <= FMT_P4_RGB8;
         image_width_ff  <= DIM_REG_W'(1);
         image_height_ff <= DIM_REG_W'(1);
      end else begin
         format_code_ff  <= format_code_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   assign fmt = decode_format(format_code_ff);

   // ---- input steering ----
   logic index_phase;
   logic take_ok;
   logic req_beat, fill_beat, index_beat;

   // palette bytes and unknown-format bytes never stall
   assign req_bus.ready = !fmt.known || !index_phase || take_ok;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign fill_beat     = req_beat && fmt.known && !index_phase;
   assign index_beat    = req_beat && fmt.known && index_phase;

   // ---- palette fill ----
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;

   ptd_palette_fill #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_fill (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .accept     (fill_beat),
      .data_byte  (req_bus.data_byte),
      .fmt        (fmt),
      .index_phase(index_phase),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata)
   );

   // ---- index issue ----
   rd_tag_type    rd_tag;
   logic [AW-1:0] ram_raddr;
   logic          room;

   ptd_index_issue #(
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_issue (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .accept      (index_beat),
      .data_byte   (req_bus.data_byte),
      .wide        (fmt.wide),
      .image_width (image_width_ff),
      .image_height(image_height_ff),
      .room        (room),
      .take_ok     (take_ok),
      .rd_tag      (rd_tag),
      .rd_addr     (ram_raddr)
   );

   // ---- palette RAM: written in palette phase, read in index phase ----
   logic [31:0] ram_rdata;

   ptd_ram #(
      .WIDTH(32),
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (rd_tag.valid),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // ---- result queue ----
   pix_type pix;

   ptd_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .rd_tag   (rd_tag),
      .rd_data  (ram_rdata),
      .rsp_ready(rsp_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_pix  (pix),
      .room     (room)
   );

   assign rsp_bus.red        = pix.red;
   assign rsp_bus.green      = pix.green;
   assign rsp_bus.blue       = pix.blue;
   assign rsp_bus.alpha      = pix.alpha;
   assign rsp_bus.last_pixel = pix.last_pixel;

   // ---- checks ----
   a_read_in_index_phase: assert property (@(posedge clock) disable iff (reset)
      rd_tag.valid |-> index_phase)
      else $error("palette read issued outside index phase");

   a_write_in_palette_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !index_phase)
      else $error("palette write during index phase");

   a_nothing_after_last: assert property (@(posedge clock) disable iff (reset)
      (rd_tag.valid && rd_tag.last) |=> !rd_tag.valid)
      else $error("pixel read issued after final pixel");

endmodule

`default_nettype wire

/* bench/tb_paletted_texture_decoder.sv */
// Self-checking bench for the paletted texture decoder: streams palette and index beats,
// predicts every RGBA pixel beat and checks it field by field on the result channel.
// Depends on ptd_pkg, the req/rsp/csr channel interfaces and paletted_texture_decoder.
`default_nettype none

module tb_paletted_texture_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import ptd_pkg::*;

   localparam int PAL_DEPTH     = 256;
   localparam int MAX_DIM       = 4096;
   // settle time after the pixel drain before a register write, with slack on top
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BEATS  = 60;

   // register index past the end of the register list: write is dropped
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   // range of format codes the block does not know
   localparam logic [FMT_W-1:0] FMT_BAD_LO = 4'd10;
   localparam logic [FMT_W-1:0] FMT_BAD_HI = 4'd15;

   logic clock = 1'b0;
   logic reset;

   ptd_req_if req_bus ();
   ptd_rsp_if rsp_bus ();
   ptd_csr_if csr_bus ();

   paletted_texture_decoder #(
      .PALETTE_DEPTH (PAL_DEPTH),
      .MAX_DIMENSION (MAX_DIM)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // ------------------------------------------------------------------
   // Shadow of the decoder: palette, entry assembly, counters, registers
   // ------------------------------------------------------------------
   logic [31:0]      shadow_palette [PAL_DEPTH];   // {a, b, g, r}
   logic [23:0]      entry_acc;
   int unsigned      pal_beats;
   int unsigned      pixels_done;
   logic             in_index;
   logic [FMT_W-1:0] cur_format;
   logic [12:0]      cur_width;
   logic [12:0]      cur_height;

   // pixels predicted but not yet seen on the result channel
   pix_type pending_pixels [$];

   int errors;
   int beats_sent;

   // sender burst shaping: gap_max of 0 means back-to-back beats
   int gap_max;
   int burst_left;

   // receiver: random ready runs, plus a long hold-off on request
   int   rsp_stall_pct;
   int   rsp_hold_cycles;
   int   run_left;
   logic run_ready;

   function automatic logic fmt_known();
      return cur_format <= FMT_P8_RGB5A1;
   endfunction

   function automatic logic fmt_wide();
      return cur_format >= FMT_P8_RGB8;
   endfunction

   function automatic enc_type fmt_enc();
      return enc_type'(cur_format % 5);
   endfunction

   function automatic int unsigned entry_size(enc_type enc);
      case (enc)
         ENC_RGB8:  return 3;
         ENC_RGBA8: return 4;
         default:   return 2;
      endcase
   endfunction

   function automatic int unsigned palette_beats();
      return (fmt_wide() ? 256 : 16) * entry_size(fmt_enc());
   endfunction

   function automatic int unsigned clamp_dim(logic [12:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

   function automatic int unsigned image_pixels();
      return clamp_dim(cur_width) * clamp_dim(cur_height);
   endfunction

   function automatic int unsigned index_beats_needed();
      return fmt_wide() ? image_pixels() : (image_pixels() + 1) / 2;
   endfunction

   // little-endian raw entry to {a, b, g, r}, narrow channels widened by
   // repeating their top bits
   function automatic logic [31:0] unpack_entry(enc_type enc, logic [31:0] raw);
      logic [15:0] h;
      logic [7:0]  r, g, b, a;
      h = raw[15:0];
      r = raw[7:0];
      g = raw[15:8];
      b = raw[23:16];
      a = 8'hFF;
      case (enc)
         ENC_RGBA8: a = raw[31:24];
         ENC_RGB565: begin
            r = {h[15:11], h[15:13]};
            g = {h[10:5], h[10:9]};
            b = {h[4:0], h[4:2]};
         end
         ENC_RGBA4: begin
            r = {2{h[15:12]}};
            g = {2{h[11:8]}};
            b = {2{h[7:4]}};
            a = {2{h[3:0]}};
         end
         ENC_RGB5A1: begin
            r = {h[15:11], h[15:13]};
            g = {h[10:6], h[10:8]};
            b = {h[5:1], h[5:3]};
            a = {8{h[0]}};
         end
         default: ;
      endcase
      return {a, b, g, r};
   endfunction

   function automatic void restart_shadow();
      entry_acc   = '0;
      pal_beats   = 0;
      pixels_done = 0;
      in_index    = 1'b0;
   endfunction

   function automatic void apply_reg(logic [CSR_ADDR_W-1:0] addr, logic [12:0] data);
      case (addr)
         CSR_FORMAT: cur_format = data[FMT_W-1:0];
         CSR_WIDTH:  cur_width  = data;
         CSR_HEIGHT: cur_height = data;
         default:    return;
      endcase
      restart_shadow();
   endfunction

   // one accepted input beat: palette byte, or index byte turning into pixels
   function automatic void decode_beat(logic [7:0] data);
      int unsigned nb, pos, slot, total, lanes;
      logic [31:0] raw;
      logic [7:0]  idx;
      pix_type     px;
      if (!fmt_known())
         return;
      nb = entry_size(fmt_enc());
      if (!in_index) begin
         pos = pal_beats % nb;
         if (pos < 3)
            entry_acc |= 24'(data) << (8 * pos);
         if (pos + 1 == nb) begin
            raw  = {((pos == 3) ? data : 8'h00), entry_acc};
            slot = pal_beats / nb;
            if (slot < PAL_DEPTH)
               shadow_palette[slot] = unpack_entry(fmt_enc(), raw);
            entry_acc = '0;
         end
         pal_beats++;
         if (pal_beats >= palette_beats()) begin
            pal_beats = 0;
            entry_acc = '0;
            in_index  = 1'b1;
         end
         return;
      end
      total = image_pixels();
      lanes = fmt_wide() ? 1 : 2;
      for (int i = 0; i < lanes; i++) begin
         if (pixels_done >= total)
            break;
         // 4-bit indices: low nibble first
         idx = fmt_wide() ? data : ((i == 0) ? {4'h0, data[3:0]} : {4'h0, data[7:4]});
         {px.alpha, px.blue, px.green, px.red} = shadow_palette[idx];
         px.last_pixel = (pixels_done + 1 == total);
         pending_pixels.push_back(px);
         pixels_done++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: ready pattern and the pixel checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_ready = ($urandom_range(99, 0) >= rsp_stall_pct);
            run_left  = $urandom_range(6, 1);
         end
         run_left--;
         rsp_bus.ready <= run_ready;
      end
   end

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      pix_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with none pending: r %0h g %0h b %0h a %0h last %0b",
                   rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.alpha,
                   rsp_bus.last_pixel);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            compare_field("red", want.red, rsp_bus.red);
            compare_field("green", want.green, rsp_bus.green);
            compare_field("blue", want.blue, rsp_bus.blue);
            compare_field("alpha", want.alpha, rsp_bus.alpha);
            compare_field("last_pixel", {7'h00, want.last_pixel},
                          {7'h00, rsp_bus.last_pixel});
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7, 0))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one input beat; valid stays high on return so the next beat can follow
   // back to back
   task automatic send_beat(logic [7:0] data);
      int gap;
      if (gap_max > 0) begin
         if (burst_left == 0) begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
               @(negedge clock) req_bus.valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(12, 1);
         end
         burst_left--;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      decode_beat(data);
      beats_sent++;
   endtask

   task automatic req_stop();
      @(negedge clock) req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_beats(int unsigned n);
      repeat (n) send_beat(pick_byte());
   endtask

   task automatic send_palette();
      send_random_beats(palette_beats());
   endtask

   // register writes only with the block quiet: input stopped, pixels drained
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [12:0] data);
      req_stop();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg(addr, data);
      @(negedge clock) csr_bus.valid <= 1'b0;
   endtask

   task automatic setup_image(logic [FMT_W-1:0] fmt, logic [12:0] w, logic [12:0] h);
      write_reg(CSR_FORMAT, 13'(fmt));
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // reset registers: 4-bit RGB8, 1x1. Palette opens with black, ends with
   // white; the one index byte has a high nibble that must be dropped, and the
   // byte after the last pixel is ignored.
   task automatic test_default_config();
      int unsigned n;
      n = palette_beats();
      for (int i = 0; i < n; i++)
         send_beat((i < 3) ? 8'h00 : ((i >= n - 3) ? 8'hFF : pick_byte()));
      send_beat(8'hFF);
      send_beat(8'h00);
      req_stop();
   endtask

   // register extremes: empty image, saturated dimensions, dropped write to an
   // unused index (no restart), and unknown format codes
   task automatic test_register_extremes();
      setup_image(FMT_P4_RGB565, 13'h1FFF, 13'd0);
      send_palette();
      send_random_beats(3);                    // zero pixels: all dropped
      write_reg(CSR_HEIGHT, 13'd4096);         // restart, 4096 x 4096 after clamp
      send_palette();
      send_random_beats(2);
      write_reg(CSR_UNUSED, 13'($urandom));    // counters must carry on
      send_random_beats(2);
      write_reg(CSR_FORMAT, 13'(FMT_BAD_HI));
      send_random_beats(4);
      write_reg(CSR_FORMAT, 13'(FMT_BAD_LO));
      send_random_beats(2);
      req_stop();
   endtask

   // 3-pixel images: the second index byte keeps only its low nibble, the third is dropped
   task automatic test_odd_pixel_count();
      logic [FMT_W-1:0] fmts [3] = '{FMT_P4_RGBA8, FMT_P4_RGBA4, FMT_P4_RGB5A1};
      for (int k = 0; k < 3; k++) begin
         setup_image(fmts[k], 13'd3, 13'd1);
         // format write with junk above bit 3: only the low bits count
         if (fmts[k] == FMT_P4_RGBA4)
            write_reg(CSR_FORMAT, {9'h1A5, fmts[k]});
         send_palette();
         send_beat(8'h21);
         send_beat(8'hA3);
         send_beat(8'h5C);
         req_stop();
      end
   endtask

   // one 8-bit index image, first and last palette entries looked up; a full
   // 256-entry palette is long, so one of the two-byte encodings is drawn
   task automatic test_wide_format();
      logic [FMT_W-1:0] fmt;
      fmt = FMT_W'($urandom_range(FMT_P8_RGB5A1, FMT_P8_RGB565));
      setup_image(fmt, 13'($urandom_range(6, 2)), 13'($urandom_range(3, 1)));
      send_palette();
      send_beat(8'h00);
      send_beat(8'hFF);
      send_random_beats(index_beats_needed() - 2 + 1);
      req_stop();
   endtask

   // mostly complete 4-bit images with random content; now and then an
   // unknown format, an empty image or an abandoned palette load
   task automatic test_random_images();
      int               start;
      int               pick;
      logic [FMT_W-1:0] fmt;
      int unsigned      w, h;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         gap_max       = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         rsp_stall_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(70, 10);
         pick = $urandom_range(99, 0);
         if (pick < 8)
            fmt = FMT_W'($urandom_range(FMT_BAD_HI, FMT_BAD_LO));
         else
            fmt = FMT_W'($urandom_range(FMT_P4_RGB5A1, FMT_P4_RGB8));
         w = ($urandom_range(14, 0) == 0) ? 0 : $urandom_range(10, 1);
         h = ($urandom_range(14, 0) == 0) ? 0 : $urandom_range(10, 1);
         setup_image(fmt, 13'(w), 13'(h));
         if (!fmt_known()) begin
            send_random_beats($urandom_range(16, 4));
            continue;
         end
         if ($urandom_range(7, 0) == 0) begin
            // partial palette, then a rewrite restarts the load
            send_random_beats($urandom_range(palette_beats() - 1, 1));
            write_reg(CSR_WIDTH, 13'(w));
         end
         send_palette();
         send_random_beats(index_beats_needed() + $urandom_range(2, 0));
      end
      req_stop();
   endtask

   // result side frozen for a long stretch while beats keep coming, so the
   // block has to back up into req; then the sender waits for a full drain
   task automatic test_backpressure();
      gap_max       = 0;
      rsp_stall_pct = 0;
      setup_image(FMT_P4_RGB565, 13'd20, 13'd4);
      send_palette();
      rsp_hold_cycles = 200;
      send_random_beats(20);
      req_stop();
      wait_drain();
      send_random_beats(21);
      req_stop();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.addr      = '0;
      csr_bus.wdata     = '0;
      rsp_bus.ready     = 1'b0;
      errors            = 0;
      beats_sent        = 0;
      burst_left        = 0;
      run_left          = 0;
      rsp_hold_cycles   = 0;
      cur_format        = FMT_P4_RGB8;
      cur_width         = 13'd1;
      cur_height        = 13'd1;
      restart_shadow();
      gap_max           = 3;
      rsp_stall_pct     = 30;

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_default_config();
      test_register_extremes();
      test_odd_pixel_count();
      test_wide_format();
      test_backpressure();
      test_random_images();

      req_stop();
      wait_drain();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
